// File: design/mcr_pkg.sv
// ----------------------------------------------------------------------------
// mcr_pkg: shared definitions for the midpoint circle rasterizer
// Default widths, group size and request opcodes.
// ----------------------------------------------------------------------------
package mcr_pkg;

    localparam int COORD_BITS_DEF  = 11;
    localparam int RADIUS_BITS_DEF = 10;

    // eight symmetric pixels per octant point
    localparam int GROUP_SIZE = 8;
    localparam int GROUP_IDX_BITS = $clog2(GROUP_SIZE);

    typedef enum logic
    {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } opcode_t;

endpackage

// File: design/mcr_if.sv
// ----------------------------------------------------------------------------
// mcr_if: request and pixel channels of the midpoint circle rasterizer
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface mcr_req_if
    import mcr_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic                   opcode;
    logic [COORD_BITS-1:0]  center_x;
    logic [COORD_BITS-1:0]  center_y;
    logic [RADIUS_BITS-1:0] radius;

    modport source (output valid, output opcode, output center_x, output center_y,
                    output radius, input ready);
    modport sink   (input valid, input opcode, input center_x, input center_y,
                    input radius, output ready);
endinterface

interface mcr_pix_if
    import mcr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [COORD_BITS+1:0]   pixel_x;
    logic signed [COORD_BITS+1:0]   pixel_y;
    logic                           last_of_group;
    logic                           circle_done;

    modport source (output valid, output pixel_x, output pixel_y,
                    output last_of_group, output circle_done, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y,
                    input last_of_group, input circle_done, output ready);
endinterface

// File: design/midpoint_circle_rasterizer.sv
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer: stepwise midpoint circle pixel generator
// Start and step requests update the octant point; each update gives 8 pixels.
// ----------------------------------------------------------------------------
// A start request loads center and radius and yields the eight symmetric
// pixels of (0, r); each step request advances the octant point and yields
// eight more. Pixels leave one per cycle on the pixel channel while it is
// ready, so a request that yields pixels occupies the block until its eighth
// pixel is handed over, and the next request is taken in that same cycle. A
// step after the circle is finished, or before any start, yields nothing.
// The octant update is done in the cycle a request is taken; the group
// register then holds the point while the pixel counter walks the octants.
module midpoint_circle_rasterizer
    import mcr_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    mcr_req_if.sink    request,
    mcr_pix_if.source  pixel
);

    localparam int PIX_BITS = COORD_BITS + 2;
    localparam int DEC_BITS = RADIUS_BITS + 3;
    localparam logic signed [DEC_BITS-1:0] DEC_ONE = DEC_BITS'(1);
    localparam logic [GROUP_IDX_BITS-1:0] LAST_IDX = GROUP_IDX_BITS'(GROUP_SIZE - 1);

    // stepper state
    logic [RADIUS_BITS-1:0]       off_x_reg, off_x_next;
    logic [RADIUS_BITS-1:0]       off_y_reg, off_y_next;
    logic signed [DEC_BITS-1:0]   dec_reg, dec_next;
    logic [COORD_BITS-1:0]        cen_x_reg, cen_x_next;
    logic [COORD_BITS-1:0]        cen_y_reg, cen_y_next;
    logic                         active_reg, active_next;

    // group register and pixel counter
    logic                         busy_reg, busy_next;
    logic [GROUP_IDX_BITS-1:0]    idx_reg, idx_next;
    logic [RADIUS_BITS-1:0]       grp_x_reg, grp_y_reg;
    logic [COORD_BITS-1:0]        grp_cx_reg, grp_cy_reg;
    logic                         grp_done_reg;

    logic                         req_take;
    logic                         pix_take;
    logic                         emit;
    logic [RADIUS_BITS-1:0]       step_x;
    logic [RADIUS_BITS-1:0]       step_y_dn;
    logic signed [DEC_BITS-1:0]   step_x_s;
    logic signed [DEC_BITS-1:0]   step_y_s;
    logic [RADIUS_BITS-1:0]       dx, dy;
    logic [PIX_BITS-1:0]          cx_ext, cy_ext, dx_ext, dy_ext;

    assign pix_take        = busy_reg && pixel.ready;
    assign request.ready   = !busy_reg || (pixel.ready && idx_reg == LAST_IDX);
    assign req_take        = request.valid && request.ready;

    assign step_x    = off_x_reg + RADIUS_BITS'(1);
    assign step_y_dn = off_y_reg - RADIUS_BITS'(1);
    assign step_x_s  = $signed(DEC_BITS'(step_x));
    assign step_y_s  = $signed(DEC_BITS'(step_y_dn));

    always_comb
    begin
        off_x_next  = off_x_reg;
        off_y_next  = off_y_reg;
        dec_next    = dec_reg;
        cen_x_next  = cen_x_reg;
        cen_y_next  = cen_y_reg;
        active_next = active_reg;
        emit        = 1'b0;
        if (req_take)
        begin
            case (request.opcode)
                OP_START:
                begin
                    cen_x_next  = request.center_x;
                    cen_y_next  = request.center_y;
                    off_x_next  = '0;
                    off_y_next  = request.radius;
                    dec_next    = DEC_ONE - $signed(DEC_BITS'(request.radius));
                    active_next = 1'b1;
                    emit        = 1'b1;
                end
                OP_STEP:
                begin
                    if (active_reg && off_x_reg < off_y_reg)
                    begin
                        off_x_next = step_x;
                        emit       = 1'b1;
                        if (dec_reg[DEC_BITS-1])
                        begin
                            dec_next = dec_reg + (step_x_s <<< 1) + DEC_ONE;
                        end
                        else
                        begin
                            off_y_next = step_y_dn;
                            dec_next   = dec_reg + ((step_x_s - step_y_s) <<< 1) + DEC_ONE;
                        end
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    // advance the pixel counter; reload on a new group, drop when drained
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (pix_take)
        begin
            idx_next = idx_reg + GROUP_IDX_BITS'(1);
            if (idx_reg == LAST_IDX)
            begin
                busy_next = 1'b0;
            end
        end
        if (emit)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_x_reg  <= '0;
            off_y_reg  <= '0;
            dec_reg    <= '0;
            cen_x_reg  <= '0;
            cen_y_reg  <= '0;
            active_reg <= 1'b0;
            busy_reg   <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            off_x_reg  <= off_x_next;
            off_y_reg  <= off_y_next;
            dec_reg    <= dec_next;
            cen_x_reg  <= cen_x_next;
            cen_y_reg  <= cen_y_next;
            active_reg <= active_next;
            busy_reg   <= busy_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            grp_x_reg    <= off_x_next;
            grp_y_reg    <= off_y_next;
            grp_cx_reg   <= cen_x_next;
            grp_cy_reg   <= cen_y_next;
            grp_done_reg <= (off_x_next >= off_y_next);
        end
    end

    // upper half of the group swaps x and y; low bits pick the signs
    assign dx     = idx_reg[2] ? grp_y_reg : grp_x_reg;
    assign dy     = idx_reg[2] ? grp_x_reg : grp_y_reg;
    assign cx_ext = PIX_BITS'(grp_cx_reg);
    assign cy_ext = PIX_BITS'(grp_cy_reg);
    assign dx_ext = PIX_BITS'(dx);
    assign dy_ext = PIX_BITS'(dy);

    assign pixel.valid         = busy_reg;
    assign pixel.pixel_x       = $signed(idx_reg[0] ? (cx_ext - dx_ext) : (cx_ext + dx_ext));
    assign pixel.pixel_y       = $signed(idx_reg[1] ? (cy_ext - dy_ext) : (cy_ext + dy_ext));
    assign pixel.last_of_group = (idx_reg == LAST_IDX);
    assign pixel.circle_done   = grp_done_reg;

endmodule
